// ===== rtl/core/bcd_pkg.sv =====
// Shared types and constants for the BC1/BC3 block decoder.
// No dependencies; every other file in rtl/core imports this package.
package bcd_pkg;

    // Reciprocal multipliers for division by small constants.
    // Each pair is exact over the full range of sums the decoder forms.
    localparam int unsigned DIV3_MUL    = 683;
    localparam int unsigned DIV3_SHIFT  = 11;
    localparam int unsigned DIV5_MUL    = 1639;
    localparam int unsigned DIV5_SHIFT  = 13;
    localparam int unsigned DIV7_MUL    = 2341;
    localparam int unsigned DIV7_SHIFT  = 14;
    localparam int unsigned DIV31_MUL   = 8457;
    localparam int unsigned DIV31_SHIFT = 18;
    localparam int unsigned DIV63_MUL   = 16645;
    localparam int unsigned DIV63_SHIFT = 20;

    localparam logic [7:0] OPAQUE = 8'd255;

    // One compressed block, as accepted on the input channel.
    typedef struct packed {
        logic [15:0] endpoint_color0;
        logic [15:0] endpoint_color1;
        logic [31:0] color_indices;
        logic [7:0]  endpoint_alpha0;
        logic [7:0]  endpoint_alpha1;
        logic [47:0] alpha_indices;
    } t_in_req;

    // One decoded pixel, as delivered on the output channel.
    typedef struct packed {
        logic [3:0] pixel_position;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
        logic       last_pixel;
    } t_out_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_rgba;

    // Fully expanded block handed from the palette pipeline to the serializer.
    typedef struct packed {
        t_rgba [3:0]      palette;
        logic [7:0][7:0]  alpha_tab;
        logic [31:0]      color_indices;
        logic [47:0]      alpha_indices;
        logic             bc3;
    } t_block;

endpackage

// ===== rtl/core/bc1_bc3_block_decoder.sv =====
// BC1/BC3 block decoder: one 4x4 compressed block in, sixteen RGBA pixels out.
// Throughput: one pixel per cycle while i_out_stall is low, set by the single-pixel
// output register; four blocks wait in the pipeline, plus the last pixel of a fifth.
// Reset (synchronous, active low) clears all valid flags and block_format (BC1).
// Depends on bcd_pkg, bcd_palette and bcd_serializer.
module bc1_bc3_block_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: block_format, 0 = BC1, 1 = BC3
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // Compressed block requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bcd_pkg::t_in_req  i_in_req,
    // Decoded pixel requests
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bcd_pkg::t_out_req o_out_req
);
    import bcd_pkg::*;

    logic   r_block_format;
    logic   blk_valid, blk_ready;
    t_block blk;

    // Hold the format; the user must change it only while the decoder is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_format <= 1'b0;
        end else if (i_cfg_we) begin
            r_block_format <= i_cfg_wdata;
        end
    end

    // Widen endpoints, form blend sums and the alpha table, then divide
    // out the palette entries; each of the three stages stalls independently.
    bcd_palette u_palette (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_format (r_block_format),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_req       (i_in_req),
        .o_blk_valid    (blk_valid),
        .i_blk_ready    (blk_ready),
        .o_blk          (blk)
    );

    // Emit the sixteen pixels in raster order; take the next block on the
    // cycle the last pixel leaves, so blocks follow without a gap.
    bcd_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_valid (blk_valid),
        .o_blk_ready (blk_ready),
        .i_blk       (blk),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/core/bcd_palette.sv =====
// Three-stage pipeline that builds the color palette and alpha table of a block.
// Depends on bcd_pkg.
module bcd_palette (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_block_format,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bcd_pkg::t_in_req i_in_req,
    output logic            o_blk_valid,
    input  logic            i_blk_ready,
    output bcd_pkg::t_block o_blk
);
    import bcd_pkg::*;

    // Rounded widening: (v*255 + 15) / 31.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [31:0] p;
        p = (32'(v) * 32'd255 + 32'd15) * 32'(DIV31_MUL);
        return p[DIV31_SHIFT +: 8];
    endfunction

    // Rounded widening: (v*255 + 31) / 63.
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [31:0] p;
        p = (32'(v) * 32'd255 + 32'd31) * 32'(DIV63_MUL);
        return p[DIV63_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [23:0] p;
        p = 24'(s) * 24'(DIV3_MUL);
        return p[DIV3_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [23:0] p;
        p = 24'(s) * 24'(DIV5_MUL);
        return p[DIV5_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [23:0] p;
        p = 24'(s) * 24'(DIV7_MUL);
        return p[DIV7_SHIFT +: 8];
    endfunction

    // Stage 1: widened endpoints, mode, alpha sums.
    logic                    r1_valid;
    logic [2:0][7:0]         r1_ep0, r1_ep1, n1_ep0, n1_ep1;
    logic                    r1_four, r1_bc3, r1_a_gt;
    logic [7:0]              r1_a0, r1_a1;
    logic [5:0][10:0]        r1_asum7, n1_asum7;
    logic [3:0][10:0]        r1_asum5, n1_asum5;
    logic [31:0]             r1_cidx;
    logic [47:0]             r1_aidx;

    // Stage 2: color sums, alpha table.
    logic                    r2_valid;
    logic [2:0][7:0]         r2_ep0, r2_ep1, r2_mid, n2_mid;
    logic [2:0][9:0]         r2_sum2, r2_sum3, n2_sum2, n2_sum3;
    logic                    r2_four, r2_bc3;
    logic [7:0][7:0]         r2_atab, n2_atab;
    logic [31:0]             r2_cidx;
    logic [47:0]             r2_aidx;

    // Stage 3: finished block.
    logic                    r3_valid;
    t_block                  r3_blk, n3_blk;

    logic adv1, adv2, adv3;

    assign adv3       = !r3_valid || i_blk_ready;
    assign adv2       = !r2_valid || adv3;
    assign adv1       = !r1_valid || adv2;
    assign o_in_stall = !adv1;
    assign o_blk_valid = r3_valid;
    assign o_blk       = r3_blk;

    always_comb begin
        logic [8:0] mid;
        n1_ep0[0] = widen5(i_in_req.endpoint_color0[15:11]);
        n1_ep0[1] = widen6(i_in_req.endpoint_color0[10:5]);
        n1_ep0[2] = widen5(i_in_req.endpoint_color0[4:0]);
        n1_ep1[0] = widen5(i_in_req.endpoint_color1[15:11]);
        n1_ep1[1] = widen6(i_in_req.endpoint_color1[10:5]);
        n1_ep1[2] = widen5(i_in_req.endpoint_color1[4:0]);
        for (int k = 1; k <= 6; k++) begin
            n1_asum7[k-1] = 11'((7 - k) * int'(i_in_req.endpoint_alpha0)
                                + k * int'(i_in_req.endpoint_alpha1) + 3);
        end
        for (int k = 1; k <= 4; k++) begin
            n1_asum5[k-1] = 11'((5 - k) * int'(i_in_req.endpoint_alpha0)
                                + k * int'(i_in_req.endpoint_alpha1) + 2);
        end

        for (int c = 0; c < 3; c++) begin
            n2_sum2[c] = {1'b0, r1_ep0[c], 1'b0} + {2'b00, r1_ep1[c]} + 10'd1;
            n2_sum3[c] = {2'b00, r1_ep0[c]} + {1'b0, r1_ep1[c], 1'b0} + 10'd1;
            mid        = {1'b0, r1_ep0[c]} + {1'b0, r1_ep1[c]} + 9'd1;
            n2_mid[c]  = mid[8:1];
        end
        n2_atab[0] = r1_a0;
        n2_atab[1] = r1_a1;
        if (r1_a_gt) begin
            for (int k = 0; k < 6; k++) begin
                n2_atab[k+2] = div7(r1_asum7[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                n2_atab[k+2] = div5(r1_asum5[k]);
            end
            n2_atab[6] = 8'd0;
            n2_atab[7] = OPAQUE;
        end

        n3_blk.palette[0] = {r2_ep0[0], r2_ep0[1], r2_ep0[2], OPAQUE};
        n3_blk.palette[1] = {r2_ep1[0], r2_ep1[1], r2_ep1[2], OPAQUE};
        if (r2_four) begin
            n3_blk.palette[2] = {div3(r2_sum2[0]), div3(r2_sum2[1]), div3(r2_sum2[2]), OPAQUE};
            n3_blk.palette[3] = {div3(r2_sum3[0]), div3(r2_sum3[1]), div3(r2_sum3[2]), OPAQUE};
        end else begin
            // Three-color mode: midpoint plus transparent black.
            n3_blk.palette[2] = {r2_mid[0], r2_mid[1], r2_mid[2], OPAQUE};
            n3_blk.palette[3] = '0;
        end
        n3_blk.alpha_tab     = r2_atab;
        n3_blk.color_indices = r2_cidx;
        n3_blk.alpha_indices = r2_aidx;
        n3_blk.bc3           = r2_bc3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_in_valid;
            if (adv2) r2_valid <= r1_valid;
            if (adv3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_ep0   <= n1_ep0;
            r1_ep1   <= n1_ep1;
            r1_bc3   <= i_block_format;
            r1_four  <= i_block_format
                        || (i_in_req.endpoint_color0 > i_in_req.endpoint_color1);
            r1_a_gt  <= i_in_req.endpoint_alpha0 > i_in_req.endpoint_alpha1;
            r1_a0    <= i_in_req.endpoint_alpha0;
            r1_a1    <= i_in_req.endpoint_alpha1;
            r1_asum7 <= n1_asum7;
            r1_asum5 <= n1_asum5;
            r1_cidx  <= i_in_req.color_indices;
            r1_aidx  <= i_in_req.alpha_indices;
        end
        if (adv2) begin
            r2_ep0  <= r1_ep0;
            r2_ep1  <= r1_ep1;
            r2_mid  <= n2_mid;
            r2_sum2 <= n2_sum2;
            r2_sum3 <= n2_sum3;
            r2_four <= r1_four;
            r2_bc3  <= r1_bc3;
            r2_atab <= n2_atab;
            r2_cidx <= r1_cidx;
            r2_aidx <= r1_aidx;
        end
        if (adv3) begin
            r3_blk <= n3_blk;
        end
    end

endmodule

// ===== rtl/core/bcd_serializer.sv =====
// Walks one expanded block pixel by pixel into the output register.
// Depends on bcd_pkg.
module bcd_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_blk_valid,
    output logic             o_blk_ready,
    input  bcd_pkg::t_block  i_blk,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output bcd_pkg::t_out_req o_out_req
);
    import bcd_pkg::*;

    logic       r_busy;
    logic [3:0] r_cnt;
    t_block     r_blk, n_blk;
    logic       r_out_valid;
    t_out_req   r_out, n_out;

    logic  out_free, emit, last;
    t_rgba pal;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = r_busy && out_free;
    assign last        = (r_cnt == '1);
    assign o_blk_ready = !r_busy || (emit && last);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_comb begin
        pal = r_blk.palette[r_blk.color_indices[1:0]];
        n_out.pixel_position = r_cnt;
        n_out.red            = pal.red;
        n_out.green          = pal.green;
        n_out.blue           = pal.blue;
        n_out.opacity        = r_blk.bc3 ? r_blk.alpha_tab[r_blk.alpha_indices[2:0]]
                                         : pal.opacity;
        n_out.last_pixel     = last;

        // Advance to the next pixel's indices.
        n_blk               = r_blk;
        n_blk.color_indices = r_blk.color_indices >> 2;
        n_blk.alpha_indices = r_blk.alpha_indices >> 3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_blk_valid && o_blk_ready) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (out_free) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_blk_valid && o_blk_ready) begin
            r_blk <= i_blk;
            r_cnt <= '0;
        end else if (emit) begin
            r_blk <= n_blk;
            r_cnt <= r_cnt + 4'd1;
        end
        if (emit) r_out <= n_out;
    end

endmodule

// ===== tb/sv/tb_bc1_bc3_block_decoder.sv =====
// Self-checking testbench for bc1_bc3_block_decoder: drives compressed blocks in BC1 and
// BC3 format and checks every decoded pixel against an in-bench palette and alpha predictor.
// Depends on bcd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_bc1_bc3_block_decoder;
    import bcd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int IDLE_PCT       = 7;
    localparam int PHASE_ITEMS    = 55;

    localparam bit FMT_BC1 = 1'b0;
    localparam bit FMT_BC3 = 1'b1;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic     i_cfg_wdata;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_req o_out_req;

    // Predictor copy of block_format, and the pixels still owed by the decoder.
    bit       fmt_bc3;
    t_out_req pixel_q[$];
    int       err_count = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_req;

    bc1_bc3_block_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_bc1_bc3_block_decoder: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned widen_565(input int unsigned v, input int unsigned maxv);
        return (v * 255 + maxv / 2) / maxv;
    endfunction

    function automatic int unsigned blend_ch(input int unsigned a, input int unsigned b,
                                             input int unsigned wa, input int unsigned wb,
                                             input int unsigned d);
        return (a * wa + b * wb + d / 2) / d;
    endfunction

    // Expand one block into its sixteen pixels and append them to pixel_q.
    function automatic void queue_block_pixels(input t_in_req blk);
        int unsigned pal_r [4];
        int unsigned pal_g [4];
        int unsigned pal_b [4];
        int unsigned pal_a [4];
        int unsigned alpha_tab [8];
        int unsigned a0, a1, ci, ai;
        bit          four_color;
        t_out_req    px;

        pal_r[0] = widen_565(32'(blk.endpoint_color0[15:11]), 31);
        pal_g[0] = widen_565(32'(blk.endpoint_color0[10:5]), 63);
        pal_b[0] = widen_565(32'(blk.endpoint_color0[4:0]), 31);
        pal_r[1] = widen_565(32'(blk.endpoint_color1[15:11]), 31);
        pal_g[1] = widen_565(32'(blk.endpoint_color1[10:5]), 63);
        pal_b[1] = widen_565(32'(blk.endpoint_color1[4:0]), 31);
        pal_a[0] = 255;
        pal_a[1] = 255;
        pal_a[2] = 255;

        // BC3 always decodes four colors; BC1 drops to three plus transparent black
        // when color0 <= color1.
        four_color = fmt_bc3 || (blk.endpoint_color0 > blk.endpoint_color1);
        if (four_color) begin
            pal_r[2] = blend_ch(pal_r[0], pal_r[1], 2, 1, 3);
            pal_g[2] = blend_ch(pal_g[0], pal_g[1], 2, 1, 3);
            pal_b[2] = blend_ch(pal_b[0], pal_b[1], 2, 1, 3);
            pal_r[3] = blend_ch(pal_r[0], pal_r[1], 1, 2, 3);
            pal_g[3] = blend_ch(pal_g[0], pal_g[1], 1, 2, 3);
            pal_b[3] = blend_ch(pal_b[0], pal_b[1], 1, 2, 3);
            pal_a[3] = 255;
        end else begin
            pal_r[2] = blend_ch(pal_r[0], pal_r[1], 1, 1, 2);
            pal_g[2] = blend_ch(pal_g[0], pal_g[1], 1, 1, 2);
            pal_b[2] = blend_ch(pal_b[0], pal_b[1], 1, 1, 2);
            pal_r[3] = 0;
            pal_g[3] = 0;
            pal_b[3] = 0;
            pal_a[3] = 0;
        end

        a0 = 32'(blk.endpoint_alpha0);
        a1 = 32'(blk.endpoint_alpha1);
        alpha_tab[0] = a0;
        alpha_tab[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k <= 6; k++)
                alpha_tab[k + 1] = ((7 - k) * a0 + k * a1 + 3) / 7;
        end else begin
            for (int k = 1; k <= 4; k++)
                alpha_tab[k + 1] = ((5 - k) * a0 + k * a1 + 2) / 5;
            alpha_tab[6] = 0;
            alpha_tab[7] = 255;
        end

        for (int i = 0; i < 16; i++) begin
            ci = 32'(blk.color_indices[2 * i +: 2]);
            ai = 32'(blk.alpha_indices[3 * i +: 3]);
            px.pixel_position = i[3:0];
            px.red            = pal_r[ci][7:0];
            px.green          = pal_g[ci][7:0];
            px.blue           = pal_b[ci][7:0];
            px.opacity        = fmt_bc3 ? alpha_tab[ai][7:0] : pal_a[ci][7:0];
            px.last_pixel     = (i == 15);
            pixel_q.push_back(px);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_in_req make_block(input logic [15:0] c0, input logic [15:0] c1,
                                           input logic [31:0] cidx, input logic [7:0] a0,
                                           input logic [7:0] a1, input logic [47:0] aidx);
        t_in_req blk;
        blk.endpoint_color0 = c0;
        blk.endpoint_color1 = c1;
        blk.color_indices   = cidx;
        blk.endpoint_alpha0 = a0;
        blk.endpoint_alpha1 = a1;
        blk.alpha_indices   = aidx;
        return blk;
    endfunction

    // Random block; tie the endpoints now and then so the equal cases show up often.
    function automatic t_in_req rand_block();
        t_in_req     blk;
        int unsigned sel;
        blk.endpoint_color0 = 16'($urandom);
        blk.endpoint_color1 = 16'($urandom);
        blk.color_indices   = $urandom;
        blk.endpoint_alpha0 = 8'($urandom);
        blk.endpoint_alpha1 = 8'($urandom);
        blk.alpha_indices   = 48'({$urandom, $urandom});
        sel = $urandom_range(7, 0);
        if (sel == 0)
            blk.endpoint_color1 = blk.endpoint_color0;
        else if (sel == 1)
            blk.endpoint_alpha1 = blk.endpoint_alpha0;
        return blk;
    endfunction

    // Offer one block request and hold it until accepted; valid stays high for the next one.
    task automatic send_block(input t_in_req blk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= blk;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        queue_block_pixels(blk);
    endtask

    // Drop valid and wait until every predicted pixel has been delivered.
    task automatic wait_all_pixels();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the decoder idle.
    task automatic write_format(input bit bc3);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bc3;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fmt_bc3 = bc3;
    endtask

    // ---------------------------------------------------------------- tests

    // BC1 palette: endpoint extremes, four-color and transparent modes, ignored alpha.
    task automatic test_bc1_palette();
        send_block(make_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h7BEF, 16'h7BEF, 32'h1B1B1B1B, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h0000, 16'h0000, 32'h00000000, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'hF800, 16'h07E0, 32'h1B1B1B1B, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h001F, 16'hF800, 32'hE4E4E4E4, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h8000, 16'h7FFF, 32'hAAAA5555, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'h7FFF, 16'h8000, 32'h5555AAAA, 8'hFF, 8'hFF,
                              48'hFFFF_FFFF_FFFF));
        wait_all_pixels();
    endtask

    // BC3: both alpha table modes, equal endpoints, index extremes, forced four colors.
    task automatic test_bc3_alpha();
        logic [47:0] ramp;
        for (int i = 0; i < 16; i++)
            ramp[3 * i +: 3] = 3'(i % 8);
        write_format(FMT_BC3);
        send_block(make_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'hFF, 8'h00, ramp));
        send_block(make_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'hFF, ramp));
        send_block(make_block(16'h7BEF, 16'h7BEF, 32'h1B1B1B1B, 8'h80, 8'h80, ramp));
        send_block(make_block(16'h0000, 16'h0000, 32'h00000000, 8'h00, 8'h00, 48'h0));
        send_block(make_block(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF,
                              48'hFFFF_FFFF_FFFF));
        send_block(make_block(16'hF800, 16'h07E0, 32'hAAAA5555, 8'h01, 8'h00, ramp));
        send_block(make_block(16'h001F, 16'hF800, 32'h5555AAAA, 8'h00, 8'h01, ramp));
        send_block(make_block(16'h1234, 16'hFEDC, 32'h0F0FF0F0, 8'h40, 8'hC0,
                              48'hFFFF_FFFF_FFFF));
        send_block(make_block(16'hFEDC, 16'h1234, 32'hF0F00F0F, 8'hC0, 8'h40, 48'h0));
        wait_all_pixels();
    endtask

    // Receiver holds off long enough for the decoder to fill and stall its input.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 12; n++)
            send_block(rand_block());
        wait_all_pixels();
    endtask

    // Random blocks in phases of BC1 and BC3 format; one phase runs with no idling.
    task automatic test_random_blocks();
        bit          phase_fmt [6] = '{FMT_BC3, FMT_BC1, FMT_BC3, FMT_BC1, FMT_BC1, FMT_BC3};
        int unsigned pause_at;
        for (int p = 0; p < 6; p++) begin
            write_format(phase_fmt[p]);
            send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            recv_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == pause_at)
                    wait_all_pixels();
                send_block(rand_block());
            end
            wait_all_pixels();
        end
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // ---------------------------------------------------------------- pixel sink and checker

    initial begin : pixel_sink
        int unsigned hold_left;
        t_out_req    want;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel request, pixel_position %0d",
                           o_out_req.pixel_position);
                    err_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (o_out_req.pixel_position !== want.pixel_position) begin
                        $error("pixel_position: expected %0d, got %0d",
                               want.pixel_position, o_out_req.pixel_position);
                        err_count++;
                    end
                    if (o_out_req.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, o_out_req.red);
                        err_count++;
                    end
                    if (o_out_req.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, o_out_req.green);
                        err_count++;
                    end
                    if (o_out_req.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, o_out_req.blue);
                        err_count++;
                    end
                    if (o_out_req.opacity !== want.opacity) begin
                        $error("opacity: expected %0d, got %0d",
                               want.opacity, o_out_req.opacity);
                        err_count++;
                    end
                    if (o_out_req.last_pixel !== want.last_pixel) begin
                        $error("last_pixel: expected %0d, got %0d",
                               want.last_pixel, o_out_req.last_pixel);
                        err_count++;
                    end
                end
            end
            // Start a long hold-off when asked, else stall at random.
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        fmt_bc3       = FMT_BC1;
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
        hold_req      = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bc1_palette();
        test_bc3_alpha();
        test_backpressure();
        test_random_blocks();
        wait_all_pixels();

        if (err_count == 0)
            $display("tb_bc1_bc3_block_decoder: done, clean");
        else
            $display("tb_bc1_bc3_block_decoder: done, errors");
        $finish;
    end

endmodule

// ===== bc1_bc3_block_decoder.f =====
rtl/core/bcd_pkg.sv
rtl/core/bcd_palette.sv
rtl/core/bcd_serializer.sv
rtl/core/bc1_bc3_block_decoder.sv
tb/sv/tb_bc1_bc3_block_decoder.sv
